>>> sv/gwwb_pkg.sv
// Shared constants and types of the greedy word-wrap breaker.
package gwwb_pkg;

  localparam int MAX_PARA_CHARS = 4096;
  localparam int IDX_W = $clog2(MAX_PARA_CHARS);
  localparam int PEN_W = 13;
  localparam int GLYPH_W = 10;
  localparam int WRAP_W = 12;
  localparam int STEP_W = 10;
  localparam int BRK_W = 13;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W = 1;
  localparam int CNT_W = $clog2(PEN_W + 1);
  localparam int Q_DEPTH = 2;
  localparam int Q_AW = $clog2(Q_DEPTH);

  localparam logic [PEN_W-1:0] PEN_MAX = {PEN_W{1'b1}};
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_PARA_CHARS - 1);

  localparam logic [CFG_IDX_W-1:0] REG_WRAP_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAB_STEP = 1'd1;
  localparam logic [WRAP_W-1:0] WRAP_WIDTH_RESET = 12'd640;
  localparam logic [STEP_W-1:0] TAB_STEP_RESET = 10'd32;

  localparam logic [1:0] KIND_TEXT = 2'd0;
  localparam logic [1:0] KIND_SPACE = 2'd1;
  localparam logic [1:0] KIND_TAB = 2'd2;

  typedef struct packed {
    logic [GLYPH_W-1:0] glyph_width;
    logic [1:0] kind;
    logic para_start;
  } char_item_t;

endpackage

>>> sv/gwwb_front.sv
// Front end: takes input transfers and classifies each character for the queue.
module gwwb_front (
  input  logic [gwwb_pkg::GLYPH_W-1:0] glyph_width,
  input  logic is_tab,
  input  logic is_space,
  input  logic paragraph_start,
  input  logic push,
  output logic full,
  input  logic q_full,
  output logic q_push,
  output gwwb_pkg::char_item_t q_item
);

  logic [1:0] kind;

  always_comb begin
    if (is_tab) begin
      kind = gwwb_pkg::KIND_TAB;
    end else if (is_space) begin
      kind = gwwb_pkg::KIND_SPACE;
    end else begin
      kind = gwwb_pkg::KIND_TEXT;
    end
  end

  assign full = q_full;
  assign q_push = push & ~q_full;
  assign q_item.glyph_width = glyph_width;
  assign q_item.kind = kind;
  assign q_item.para_start = paragraph_start;

endmodule

>>> sv/gwwb_queue.sv
// Short queue of classified characters between the front end and the back end.
module gwwb_queue (
  input  logic clk,
  input  logic rst,
  input  logic wr_push,
  input  gwwb_pkg::char_item_t wr_item,
  output logic q_full,
  input  logic rd_pop,
  output logic rd_valid,
  output gwwb_pkg::char_item_t rd_item
);

  gwwb_pkg::char_item_t mem [gwwb_pkg::Q_DEPTH];
  logic [gwwb_pkg::Q_AW-1:0] wptr;
  logic [gwwb_pkg::Q_AW-1:0] rptr;
  logic [gwwb_pkg::Q_AW:0] count;
  logic do_push;
  logic do_pop;

  assign q_full = (count == (gwwb_pkg::Q_AW + 1)'(gwwb_pkg::Q_DEPTH));
  assign rd_valid = (count != '0);
  assign do_push = wr_push & ~q_full;
  assign do_pop = rd_pop & rd_valid;
  assign rd_item = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= (wptr == gwwb_pkg::Q_AW'(gwwb_pkg::Q_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == gwwb_pkg::Q_AW'(gwwb_pkg::Q_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> sv/gwwb_back.sv
// Back end: tab expansion by iterative remainder, pen tracking and break decisions.
module gwwb_back (
  input  logic clk,
  input  logic rst,
  input  logic [gwwb_pkg::WRAP_W-1:0] wrap_width,
  input  logic [gwwb_pkg::STEP_W-1:0] tab_step,
  input  logic q_valid,
  input  gwwb_pkg::char_item_t q_item,
  output logic q_pop,
  output logic [gwwb_pkg::GLYPH_W-1:0] cell_width,
  output logic break_valid,
  output logic [gwwb_pkg::BRK_W-1:0] break_index,
  output logic empty,
  input  logic pop
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV = 2'd1;
  localparam logic [1:0] ST_FIN = 2'd2;

  logic [1:0] state;
  gwwb_pkg::char_item_t item;
  logic [gwwb_pkg::STEP_W-1:0] step;
  logic [gwwb_pkg::STEP_W-1:0] rem;
  logic [gwwb_pkg::PEN_W-1:0] dvd;
  logic [gwwb_pkg::CNT_W-1:0] cnt;

  logic [gwwb_pkg::PEN_W-1:0] pen_x;
  logic [gwwb_pkg::IDX_W-1:0] char_index;
  logic space_seen;
  logic [gwwb_pkg::IDX_W-1:0] space_index;
  logic [gwwb_pkg::PEN_W-1:0] space_end_x;

  logic out_valid;

  logic [gwwb_pkg::STEP_W:0] trial;
  logic [gwwb_pkg::STEP_W-1:0] rem_next;
  logic [gwwb_pkg::GLYPH_W-1:0] cw;
  logic [gwwb_pkg::PEN_W:0] sum;
  logic [gwwb_pkg::PEN_W-1:0] x_sat;
  logic is_blank;
  logic ss_new;
  logic [gwwb_pkg::IDX_W-1:0] si_new;
  logic [gwwb_pkg::PEN_W-1:0] se_new;
  logic wraps;
  logic [gwwb_pkg::PEN_W-1:0] pen_next;
  logic space_seen_next;
  logic [gwwb_pkg::BRK_W-1:0] brk_next;
  logic fin_fire;
  logic take;

  assign trial = {rem, dvd[gwwb_pkg::PEN_W-1]};
  assign rem_next = (trial >= {1'b0, step}) ? gwwb_pkg::STEP_W'(trial - {1'b0, step})
                                            : trial[gwwb_pkg::STEP_W-1:0];

  assign is_blank = (item.kind == gwwb_pkg::KIND_TAB) || (item.kind == gwwb_pkg::KIND_SPACE);

  always_comb begin
    if (item.kind == gwwb_pkg::KIND_TAB) begin
      cw = gwwb_pkg::GLYPH_W'(step - rem);
    end else begin
      cw = item.glyph_width;
    end
    sum = {1'b0, pen_x} + (gwwb_pkg::PEN_W + 1)'(cw);
    x_sat = sum[gwwb_pkg::PEN_W] ? gwwb_pkg::PEN_MAX : sum[gwwb_pkg::PEN_W-1:0];
    ss_new = is_blank | space_seen;
    si_new = is_blank ? char_index : space_index;
    se_new = is_blank ? x_sat : space_end_x;
    wraps = x_sat > gwwb_pkg::PEN_W'(wrap_width);
    pen_next = x_sat;
    space_seen_next = ss_new;
    brk_next = '0;
    if (wraps) begin
      if (ss_new) begin
        brk_next = gwwb_pkg::BRK_W'(si_new) + gwwb_pkg::BRK_W'(1);
        space_seen_next = 1'b0;
        pen_next = (se_new > x_sat) ? '0 : x_sat - se_new;
      end else begin
        brk_next = gwwb_pkg::BRK_W'(char_index);
        pen_next = gwwb_pkg::PEN_W'(cw);
      end
    end
  end

  assign take = (state == ST_IDLE) && q_valid;
  assign q_pop = take;
  assign fin_fire = (state == ST_FIN) && (!out_valid || pop);
  assign empty = ~out_valid;

  always_ff @(posedge clk) begin
    if (take) begin
      item <= q_item;
      step <= (tab_step == '0) ? gwwb_pkg::STEP_W'(1) : tab_step;
      dvd <= q_item.para_start ? '0 : pen_x;
    end else if (state == ST_DIV) begin
      dvd <= dvd << 1;
    end
    if (fin_fire) begin
      cell_width <= cw;
      break_valid <= wraps;
      break_index <= brk_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      rem <= '0;
      cnt <= '0;
      pen_x <= '0;
      char_index <= '0;
      space_seen <= 1'b0;
      space_index <= '0;
      space_end_x <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fin_fire) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (take) begin
            rem <= '0;
            cnt <= '0;
            if (q_item.para_start) begin
              pen_x <= '0;
              char_index <= '0;
              space_seen <= 1'b0;
              space_index <= '0;
              space_end_x <= '0;
            end
            state <= (q_item.kind == gwwb_pkg::KIND_TAB) ? ST_DIV : ST_FIN;
          end
        end
        ST_DIV: begin
          rem <= rem_next;
          cnt <= cnt + 1'b1;
          if (cnt == gwwb_pkg::CNT_W'(gwwb_pkg::PEN_W - 1)) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (fin_fire) begin
            pen_x <= pen_next;
            space_seen <= space_seen_next;
            space_index <= si_new;
            space_end_x <= se_new;
            if (char_index < gwwb_pkg::IDX_MAX) begin
              char_index <= char_index + 1'b1;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_rem_below_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < step))
    else $error("remainder not below tab step during division");

  a_div_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (cnt < gwwb_pkg::CNT_W'(gwwb_pkg::PEN_W)))
    else $error("division step count out of range");

  a_fin_loads_result: assert property (@(posedge clk) disable iff (rst)
    fin_fire |=> (out_valid && state == ST_IDLE))
    else $error("finished character did not reach the result register");

  a_no_break_zero_index: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !break_valid) |-> (break_index == '0))
    else $error("break index set without a break");

endmodule

>>> sv/greedy_word_wrap_breaker_unit.sv
// Greedy word-wrap breaker: one character in, its cell width and any line break out.
// Each pushed character produces exactly one result. A plain character or space goes
// from idle straight to the finish state; a tab first passes the division state, as
// the distance to the next tab stop needs the pen position modulo tab_step, worked
// out one quotient bit per cycle over the 13 bits of the pen. A two-entry queue behind
// the input side and a one-entry result register let pushes and pops proceed while a
// character is being worked on. The user must write wrap_width (index 0) and tab_step
// (index 1) through wr_en, wr_index and wr_data while the block is idle, unchecked.
module greedy_word_wrap_breaker_unit (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  logic [gwwb_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [gwwb_pkg::CFG_DATA_W-1:0] wr_data,
  input  logic [gwwb_pkg::GLYPH_W-1:0] glyph_width,
  input  logic is_tab,
  input  logic is_space,
  input  logic paragraph_start,
  input  logic push,
  output logic full,
  output logic [gwwb_pkg::GLYPH_W-1:0] cell_width,
  output logic break_valid,
  output logic [gwwb_pkg::BRK_W-1:0] break_index,
  output logic empty,
  input  logic pop
);

  logic [gwwb_pkg::WRAP_W-1:0] wrap_width;
  logic [gwwb_pkg::STEP_W-1:0] tab_step;
  logic q_full;
  logic q_push;
  gwwb_pkg::char_item_t q_wr_item;
  logic q_pop;
  logic q_valid;
  gwwb_pkg::char_item_t q_rd_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      wrap_width <= gwwb_pkg::WRAP_WIDTH_RESET;
      tab_step <= gwwb_pkg::TAB_STEP_RESET;
    end else if (wr_en) begin
      case (wr_index)
        gwwb_pkg::REG_WRAP_WIDTH: wrap_width <= wr_data[gwwb_pkg::WRAP_W-1:0];
        gwwb_pkg::REG_TAB_STEP: tab_step <= wr_data[gwwb_pkg::STEP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  gwwb_front u_front (
    .glyph_width(glyph_width),
    .is_tab(is_tab),
    .is_space(is_space),
    .paragraph_start(paragraph_start),
    .push(push),
    .full(full),
    .q_full(q_full),
    .q_push(q_push),
    .q_item(q_wr_item)
  );

  gwwb_queue u_queue (
    .clk(clk),
    .rst(rst),
    .wr_push(q_push),
    .wr_item(q_wr_item),
    .q_full(q_full),
    .rd_pop(q_pop),
    .rd_valid(q_valid),
    .rd_item(q_rd_item)
  );

  gwwb_back u_back (
    .clk(clk),
    .rst(rst),
    .wrap_width(wrap_width),
    .tab_step(tab_step),
    .q_valid(q_valid),
    .q_item(q_rd_item),
    .q_pop(q_pop),
    .cell_width(cell_width),
    .break_valid(break_valid),
    .break_index(break_index),
    .empty(empty),
    .pop(pop)
  );

endmodule
